// ----- rtl/core/msht_pkg.sv -----
// Shared types and constants for the miss status holding table.
// Holds table sizes, request and result structs, command and status codes.
// No dependencies.
package msht_pkg;

	localparam int ENTRIES = 16;
	localparam int ADDR_BITS = 48;

	localparam int LINE_ADDR_W = 48;
	localparam int OCC_W = 5;
	localparam int STATUS_W = 3;
	localparam int CMD_W = 2;

	localparam int STORE_W = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ISSUE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUP_FAULT = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]       command;
		logic [LINE_ADDR_W-1:0] line_addr;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic                   pending_valid;
		logic [LINE_ADDR_W-1:0] pending_addr;
		logic [OCC_W-1:0]       occupancy;
	} result_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic report;
	} ctl_t;

endpackage

// ----- rtl/core/msht_ctrl.sv -----
// Sequencer for the miss status holding table.
// Steps each request through capture, update and report; uses msht_pkg.
module msht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output msht_pkg::ctl_t ctl
);
	import msht_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_REPORT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_APPLY;
						busy_q  <= 1'b1;
					end
				end
				S_APPLY: begin
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign ctl.capture = start && !busy_q;
	assign ctl.apply   = (state_q == S_APPLY);
	assign ctl.report  = (state_q == S_REPORT);

endmodule

// ----- rtl/core/msht_datapath.sv -----
// Entry table, age matrix and result logic of the miss status holding table.
// Driven by msht_ctrl through msht_pkg::ctl_t; uses msht_pkg.
module msht_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  msht_pkg::ctl_t    ctl,
	input  msht_pkg::req_t    req,
	input  logic              cfg_we,
	input  logic              cfg_data,
	output msht_pkg::result_t result
);
	import msht_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [STORE_W-1:0] addr_q [ENTRIES];
	logic [ENTRIES-1:0] issued_q;
	logic [ENTRIES-1:0] older_q [ENTRIES];
	logic               prefetch_q;

	logic [CMD_W-1:0]    cmd_s1;
	logic [STORE_W-1:0]  addr_s1;
	logic [ENTRIES-1:0]  hit_s1;
	logic [ENTRIES-1:0]  free_s1;
	logic [STATUS_W-1:0] status_s2;
	result_t             result_q;

	logic [STORE_W-1:0]  addr_in;
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  free_vec;
	logic [ENTRIES-1:0]  free_oh;
	logic                hit_any;
	logic                free_any;
	logic [STATUS_W-1:0] status_d;
	logic [ENTRIES-1:0]  wait_vec;
	logic [ENTRIES-1:0]  oldest;
	logic [STORE_W-1:0]  pend_addr;
	logic [CNT_W-1:0]    occ;

	assign addr_in  = req.line_addr[STORE_W-1:0];
	assign free_vec = ~valid_q;
	assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (addr_q[i] == addr_in);
		end
	end

	assign hit_any  = |hit_s1;
	assign free_any = |free_s1;

	always_comb begin
		status_d = ST_OK;
		case (cmd_s1)
			CMD_ADD: begin
				if (hit_any) begin
					status_d = prefetch_q ? ST_DUP : ST_DUP_FAULT;
				end else if (!free_any) begin
					status_d = ST_FULL;
				end
			end
			CMD_ISSUE, CMD_FINISH: begin
				if (!hit_any) begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign wait_vec = valid_q & ~issued_q;

	always_comb begin
		pend_addr = '0;
		occ       = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			oldest[i] = wait_vec[i] && ((older_q[i] & wait_vec) == '0);
			if (oldest[i]) begin
				pend_addr = pend_addr | addr_q[i];
			end
			occ = occ + CNT_W'(valid_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			prefetch_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				older_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				prefetch_q <= cfg_data;
			end
			if (ctl.apply) begin
				case (cmd_s1)
					CMD_ADD: begin
						if (!hit_any && free_any) begin
							valid_q <= valid_q | free_s1;
							for (int i = 0; i < ENTRIES; i++) begin
								if (free_s1[i]) begin
									older_q[i] <= valid_q;
								end
							end
						end
					end
					CMD_FINISH: begin
						if (hit_any) begin
							valid_q <= valid_q & ~hit_s1;
							for (int i = 0; i < ENTRIES; i++) begin
								older_q[i] <= hit_s1[i] ? '0 : (older_q[i] & ~hit_s1);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1  <= req.command;
			addr_s1 <= addr_in;
			hit_s1  <= match;
			free_s1 <= free_oh;
		end
		if (ctl.apply) begin
			status_s2 <= status_d;
			case (cmd_s1)
				CMD_ADD: begin
					if (!hit_any) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (free_s1[i]) begin
								addr_q[i]   <= addr_s1;
								issued_q[i] <= 1'b0;
							end
						end
					end
				end
				CMD_ISSUE: begin
					issued_q <= issued_q | hit_s1;
				end
				default: begin
				end
			endcase
		end
		if (ctl.report) begin
			result_q.status        <= status_s2;
			result_q.pending_valid <= |oldest;
			result_q.pending_addr  <= LINE_ADDR_W'(pend_addr);
			result_q.occupancy     <= OCC_W'(occ);
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/core/miss_status_holding_table.sv -----
// Miss status holding table: top level joining the sequencer and the entry table.
// The result and its strobe are registered in the report step that follows update.
// A new request is taken only once the last one has passed capture, update and report.
// The lookup compares all entries in the capture step; results cannot be stalled.
// Reset empties the table and clears the prefetch flag; configuration is always ready.
module miss_status_holding_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  msht_pkg::req_t    req,
	output logic              done,
	output msht_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import msht_pkg::*;

	ctl_t ctl;

	assign cfg_ready = 1'b1;

	msht_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.ctl   (ctl)
	);

	msht_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.req     (req),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.result  (result)
	);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing three cycles after a request");

	a_pending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.pending_valid |-> result.pending_addr == '0)
		else $error("pending address not zero without a pending entry");

endmodule
